// ===== hdl/phbh_pkg.sv =====
// package for the push-button hold classifier
// types, codes, constants and the counter update function; no dependencies
package phbh_pkg;

  // widths of the counters and of the pulse walk accumulator
  localparam int unsigned CntW   = 16;
  localparam int unsigned PerW   = 8;
  localparam int unsigned PulseW = 6;
  localparam int unsigned AccW   = 22;

  // pulse limits of the select switch
  localparam logic [PulseW-1:0] MaxPulses  = PulseW'(60);
  localparam logic [PulseW-1:0] HalfPulses = PulseW'(20);

  // register reset values
  localparam logic [CntW-1:0] FullReset   = CntW'(300);
  localparam logic [CntW-1:0] HalfReset   = CntW'(100);
  localparam logic [CntW-1:0] MinReset    = CntW'(10);
  localparam logic [PerW-1:0] PeriodReset = PerW'(2);

  // decay steps of a released switch
  localparam logic [CntW-1:0] DecayBigLim  = CntW'(50);
  localparam logic [CntW-1:0] DecayMidLim  = CntW'(10);
  localparam logic [CntW-1:0] DecayMidStep = CntW'(5);

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_FULL   = 2'd0,
    REG_HALF   = 2'd1,
    REG_MIN    = 2'd2,
    REG_PERIOD = 2'd3
  } reg_idx_e;

  // result action codes
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_UP    = 3'd1,
    ACT_DOWN  = 3'd2,
    ACT_ENTER = 3'd3,
    ACT_BACK  = 3'd4
  } action_e;

  // shared unit operations
  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_e;

  // configuration register set
  typedef struct packed {
    logic [CntW-1:0] full_thr;
    logic [CntW-1:0] half_thr;
    logic [CntW-1:0] min_thr;
    logic [PerW-1:0] period;
  } cfg_t;

  // grow a held switch counter, let a released one decay
  function automatic logic [CntW-1:0] decay_or_grow(input logic [CntW-1:0] cnt,
                                                    input logic pressed);
    logic [CntW-1:0] res;
    res = cnt;
    if (pressed) begin
      if (cnt != {CntW{1'b1}}) res = cnt + CntW'(1);
    end else if (cnt > DecayBigLim) begin
      res = cnt - DecayBigLim;
    end else if (cnt > DecayMidLim) begin
      res = cnt - DecayMidStep;
    end else if (cnt != '0) begin
      res = cnt - CntW'(1);
    end
    return res;
  endfunction

endpackage

// ===== hdl/phbh_alu.sv =====
// shared add / subtract-compare unit of the hold classifier
// depends on phbh_pkg
module phbh_alu (
  input  phbh_pkg::alu_op_e             op_i,
  input  logic [phbh_pkg::AccW-1:0]     a_i,
  input  logic [phbh_pkg::AccW-1:0]     b_i,
  output logic [phbh_pkg::AccW-1:0]     res_o,
  output logic                          gt_o
);
  import phbh_pkg::*;

  logic [AccW:0] sum;

  // one wide adder, subtract reuses it through the borrow bit
  always_comb begin
    if (op_i == ALU_ADD) begin
      sum = {1'b0, a_i} + {1'b0, b_i};
    end else begin
      sum = {1'b0, a_i} - {1'b0, b_i};
    end
  end

  assign res_o = sum[AccW-1:0];
  // a > b when no borrow and a nonzero difference
  assign gt_o  = (op_i == ALU_SUB) && !sum[AccW] && (sum[AccW-1:0] != '0);

endmodule

// ===== hdl/phbh_cfg.sv =====
// configuration registers behind a simple peripheral bus port
// depends on phbh_pkg
module phbh_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output phbh_pkg::cfg_t      cfg_o
);
  import phbh_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FULL:   cfg_d.full_thr = pwdata[CntW-1:0];
        REG_HALF:   cfg_d.half_thr = pwdata[CntW-1:0];
        REG_MIN:    cfg_d.min_thr  = pwdata[CntW-1:0];
        REG_PERIOD: cfg_d.period   = pwdata[PerW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{full_thr: FullReset, half_thr: HalfReset,
                 min_thr: MinReset, period: PeriodReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_FULL:   prdata = {{(32-CntW){1'b0}}, cfg_q.full_thr};
      REG_HALF:   prdata = {{(32-CntW){1'b0}}, cfg_q.half_thr};
      REG_MIN:    prdata = {{(32-CntW){1'b0}}, cfg_q.min_thr};
      REG_PERIOD: prdata = {{(32-PerW){1'b0}}, cfg_q.period};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/phbh_seq.sv =====
// sequencer of the hold classifier: sampling, hold checks and pulse walk
// depends on phbh_pkg and phbh_alu
module phbh_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  phbh_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  up_i,
  input  logic                  dn_i,
  input  logic                  sel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output phbh_pkg::action_e     action_o,
  output logic                  sampled_o
);
  import phbh_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FULL   = 8'b0000_0010,
    S_HALF   = 8'b0000_0100,
    S_MIN    = 8'b0000_1000,
    S_SELST  = 8'b0001_0000,
    S_WALK   = 8'b0010_0000,
    S_SELCMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [PerW-1:0]   pre_q, pre_d;
  logic [CntW-1:0]   up_q, up_d, dn_q, dn_d, sel_q, sel_d;
  logic [PulseW-1:0] sp_q, sp_d, k_q, k_d;
  logic [AccW-1:0]   acc_q, acc_d;
  action_e           act_q, act_d;
  logic              smp_q, smp_d;
  logic              cur_dn_q, cur_dn_d;
  logic              ov_q, ov_d;
  action_e           oact_q, oact_d;
  logic              osmp_q, osmp_d;

  alu_op_e           alu_op;
  logic [AccW-1:0]   alu_a, alu_b, alu_res;
  logic              alu_gt;
  logic [CntW-1:0]   cnt;
  logic [PerW-1:0]   pre_dec;
  logic [PulseW-1:0] sp_inc, k_inc;
  logic              out_free;

  phbh_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .gt_o  (alu_gt)
  );

  assign cnt       = cur_dn_q ? dn_q : up_q;
  assign pre_dec   = (pre_q != '0) ? pre_q - PerW'(1) : pre_q;
  assign sp_inc    = sp_q + PulseW'(1);
  assign k_inc     = k_q + PulseW'(1);
  assign out_free  = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // shared unit operand selection
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = {{(AccW-CntW){1'b0}}, cnt};
    alu_b  = {{(AccW-CntW){1'b0}}, cfg_i.full_thr};
    unique case (state_q)
      S_HALF:   alu_b = {{(AccW-CntW){1'b0}}, cfg_i.half_thr};
      S_MIN:    alu_b = {{(AccW-CntW){1'b0}}, cfg_i.min_thr};
      S_WALK: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = {{(AccW-CntW){1'b0}}, cfg_i.min_thr};
      end
      S_SELCMP: begin
        alu_a = {{(AccW-CntW){1'b0}}, sel_q};
        alu_b = acc_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    pre_d    = pre_q;
    up_d     = up_q;
    dn_d     = dn_q;
    sel_d    = sel_q;
    sp_d     = sp_q;
    k_d      = k_q;
    acc_d    = acc_q;
    act_d    = act_q;
    smp_d    = smp_q;
    cur_dn_d = cur_dn_q;
    ov_d     = ov_q;
    oact_d   = oact_q;
    osmp_d   = osmp_q;

    // output register drains independently
    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // prescaler tick, then switch update on a sample
          act_d    = ACT_NONE;
          cur_dn_d = 1'b0;
          if (pre_dec == '0) begin
            up_d  = decay_or_grow(up_q, up_i);
            dn_d  = decay_or_grow(dn_q, dn_i);
            sel_d = decay_or_grow(sel_q, sel_i);
            pre_d = cfg_i.period;
            smp_d = 1'b1;
          end else begin
            pre_d = pre_dec;
            smp_d = 1'b0;
          end
          state_d = S_FULL;
        end
      end
      S_FULL: begin
        if (alu_gt) begin
          act_d   = cur_dn_q ? ACT_DOWN : ACT_UP;
          cur_dn_d = 1'b1;
          state_d = cur_dn_q ? S_SELST : S_FULL;
        end else begin
          state_d = S_HALF;
        end
      end
      S_HALF: begin
        if (alu_gt) begin
          act_d    = cur_dn_q ? ACT_DOWN : ACT_UP;
          cur_dn_d = 1'b1;
          state_d  = cur_dn_q ? S_SELST : S_FULL;
        end else begin
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        // minimal hit takes the repeat step off the counter
        if (alu_gt) begin
          act_d = cur_dn_q ? ACT_DOWN : ACT_UP;
          if (cur_dn_q) dn_d = alu_res[CntW-1:0];
          else          up_d = alu_res[CntW-1:0];
        end
        cur_dn_d = 1'b1;
        state_d  = cur_dn_q ? S_SELST : S_FULL;
      end
      S_SELST: begin
        acc_d = '0;
        k_d   = '0;
        if (sel_q == '0) begin
          sp_d    = '0;
          state_d = S_DONE;
        end else if (sp_q < MaxPulses - PulseW'(1)) begin
          state_d = S_WALK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        // build min * (pulses + 1) one addition a cycle
        acc_d = alu_res;
        k_d   = k_inc;
        if (k_inc == sp_inc) state_d = S_SELCMP;
      end
      S_SELCMP: begin
        if (alu_gt) begin
          sp_d  = sp_inc;
          act_d = (sp_inc > HalfPulses) ? ACT_BACK : ACT_ENTER;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oact_d  = act_q;
          osmp_d  = smp_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pre_q    <= '0;
      up_q     <= '0;
      dn_q     <= '0;
      sel_q    <= '0;
      sp_q     <= '0;
      cur_dn_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      pre_q    <= pre_d;
      up_q     <= up_d;
      dn_q     <= dn_d;
      sel_q    <= sel_d;
      sp_q     <= sp_d;
      cur_dn_q <= cur_dn_d;
      ov_q     <= ov_d;
    end
  end

  // working and output payload
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    acc_q  <= acc_d;
    act_q  <= act_d;
    smp_q  <= smp_d;
    oact_q <= oact_d;
    osmp_q <= osmp_d;
  end

  assign out_valid_o = ov_q;
  assign action_o    = oact_q;
  assign sampled_o   = osmp_q;

endmodule

// ===== hdl/push_button_hold_classifier_top.sv =====
// per input beat the up and then the down counter are checked against the full, half and
// minimal thresholds until one is exceeded, then a held select below its pulse limit adds
// the minimal threshold once for each counted pulse plus one and compares; one beat at a time
// a finished result waits in an output register while the next beat is taken
// reset: asynchronous, active low; counters and prescaler clear, registers take
// their reset values, no result pending
module push_button_hold_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] up_pressed, [1] down_pressed,
                                      // [2] select_pressed, [7:3] zero
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [2:0] action, [3] sampled, [7:4] zero
);
  import phbh_pkg::*;

  cfg_t    cfg;
  action_e action;
  logic    sampled;

  phbh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phbh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .up_i        (s_axis_tdata[0]),
    .dn_i        (s_axis_tdata[1]),
    .sel_i       (s_axis_tdata[2]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .action_o    (action),
    .sampled_o   (sampled)
  );

  // pack result fields
  assign m_axis_tdata = {4'b0000, sampled, action};

endmodule
